// ===== design/lsrf_pkg.sv =====
// ----------------------------------------------------------------------------
// Longest sleep run finder package
// Shared constants and the classified sample flags passed from the front end
// to the run tracker.
// ----------------------------------------------------------------------------
package lsrf_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int GAP_WIDTH       = 16;
    localparam int CODE_WIDTH      = 2;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [GAP_WIDTH-1:0]  GAP_RESET     = 16'd3600;
    localparam logic [CODE_WIDTH-1:0] CODE_AWAKE    = 2'd3;
    localparam logic [CODE_WIDTH-1:0] CODE_RESTLESS = 2'd2;

    typedef struct packed {
        logic brk;
        logic awake;
        logic restless;
        logic last;
    } sample_class_t;

    localparam int CLASS_WIDTH = $bits(sample_class_t);

endpackage

// ===== design/lsrf_front.sv =====
// ----------------------------------------------------------------------------
// Longest sleep run finder front end
// Accepts sample beats, holds the gap limit, and tags each sample with its
// gap break and its sleep class before it enters the queue.
// ----------------------------------------------------------------------------
module lsrf_front #(
    parameter int TIME_WIDTH = lsrf_pkg::TIME_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [lsrf_pkg::GAP_WIDTH-1:0]       cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [TIME_WIDTH-1:0]                s_timestamp,
    input  logic [lsrf_pkg::CODE_WIDTH-1:0]      s_sleep_code,
    input  logic                                 s_last,
    output logic                                 q_wr_valid,
    input  logic                                 q_wr_ready,
    output logic [TIME_WIDTH-1:0]                q_wr_time,
    output lsrf_pkg::sample_class_t              q_wr_class
);
    import lsrf_pkg::*;

    logic [GAP_WIDTH-1:0]  gap_limit_reg, gap_limit_next;
    logic [TIME_WIDTH-1:0] prev_time_reg, prev_time_next;
    logic                  seen_reg, seen_next;
    logic [TIME_WIDTH-1:0] diff;
    logic                  accept;

    always_comb begin
        diff   = s_timestamp - prev_time_reg;
        accept = s_valid && q_wr_ready;

        q_wr_valid          = s_valid;
        s_ready             = q_wr_ready;
        q_wr_time           = s_timestamp;
        q_wr_class.brk      = seen_reg && (s_timestamp > prev_time_reg)
                              && (diff > TIME_WIDTH'(gap_limit_reg));
        q_wr_class.awake    = (s_sleep_code == CODE_AWAKE);
        q_wr_class.restless = (s_sleep_code == CODE_RESTLESS);
        q_wr_class.last     = s_last;

        gap_limit_next = cfg_wr_en ? cfg_wr_data : gap_limit_reg;
        prev_time_next = accept ? s_timestamp : prev_time_reg;
        seen_next      = accept ? !s_last : seen_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_limit_reg <= GAP_RESET;
            seen_reg      <= 1'b0;
        end else begin
            gap_limit_reg <= gap_limit_next;
            seen_reg      <= seen_next;
        end
        prev_time_reg <= prev_time_next;
    end

endmodule

// ===== design/lsrf_queue.sv =====
// ----------------------------------------------------------------------------
// Longest sleep run finder queue
// Small first-in first-out buffer that decouples the front end from the run
// tracker.
// ----------------------------------------------------------------------------
module lsrf_queue #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = lsrf_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  logic [DATA_WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output logic [DATA_WIDTH-1:0] rd_data
);
    localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

    logic [DATA_WIDTH-1:0] store [DEPTH];
    logic [PTR_WIDTH-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0]  count_reg, count_next;
    logic                  push, pop;

    always_comb begin
        wr_ready = (count_reg != CNT_FULL);
        rd_valid = (count_reg != '0);
        rd_data  = store[rd_ptr_reg];
        push     = wr_valid && wr_ready;
        pop      = rd_valid && rd_ready;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_WIDTH'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_WIDTH'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_WIDTH'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/lsrf_back.sv =====
// ----------------------------------------------------------------------------
// Longest sleep run finder run tracker
// Tracks the current run, the longest run and the stream totals, and loads
// the result register on the last sample of a stream.
// ----------------------------------------------------------------------------
module lsrf_back #(
    parameter int COUNT_WIDTH = lsrf_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = lsrf_pkg::TIME_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_rd_valid,
    output logic                     q_rd_ready,
    input  logic [TIME_WIDTH-1:0]    q_rd_time,
    input  lsrf_pkg::sample_class_t  q_rd_class,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [TIME_WIDTH-1:0]    m_start_time,
    output logic [TIME_WIDTH-1:0]    m_end_time,
    output logic [COUNT_WIDTH-1:0]   m_sample_count,
    output logic [COUNT_WIDTH-1:0]   m_awake_count,
    output logic [COUNT_WIDTH-1:0]   m_restless_count,
    output logic                     m_whole_range
);
    import lsrf_pkg::*;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    logic                   in_run_reg, in_run_next;
    logic                   seen_reg, seen_next;
    logic [TIME_WIDTH-1:0]  run_start_reg, run_start_next;
    logic [TIME_WIDTH-1:0]  run_end_reg, run_end_next;
    logic [COUNT_WIDTH-1:0] run_samples_reg, run_samples_next;
    logic [COUNT_WIDTH-1:0] run_awake_reg, run_awake_next;
    logic [COUNT_WIDTH-1:0] run_restless_reg, run_restless_next;
    logic                   best_valid_reg, best_valid_next;
    logic [TIME_WIDTH-1:0]  best_start_reg, best_start_next;
    logic [TIME_WIDTH-1:0]  best_end_reg, best_end_next;
    logic [COUNT_WIDTH-1:0] best_samples_reg, best_samples_next;
    logic [COUNT_WIDTH-1:0] best_awake_reg, best_awake_next;
    logic [COUNT_WIDTH-1:0] best_restless_reg, best_restless_next;
    logic [TIME_WIDTH-1:0]  first_time_reg, first_time_next;
    logic [COUNT_WIDTH-1:0] total_samples_reg, total_samples_next;
    logic [COUNT_WIDTH-1:0] total_awake_reg, total_awake_next;

    logic                   out_valid_reg, out_valid_next;
    logic [TIME_WIDTH-1:0]  out_start_reg, out_start_next;
    logic [TIME_WIDTH-1:0]  out_end_reg, out_end_next;
    logic [COUNT_WIDTH-1:0] out_samples_reg, out_samples_next;
    logic [COUNT_WIDTH-1:0] out_awake_reg, out_awake_next;
    logic [COUNT_WIDTH-1:0] out_restless_reg, out_restless_next;
    logic                   out_whole_reg, out_whole_next;

    logic                   pop;
    logic                   close_gap;
    logic                   close_end;
    logic                   run_live;
    logic                   b_valid;
    logic [TIME_WIDTH-1:0]  b_start, b_end;
    logic [COUNT_WIDTH-1:0] b_samples, b_awake, b_restless;
    logic                   r_in_run;
    logic [TIME_WIDTH-1:0]  r_start, r_end;
    logic [COUNT_WIDTH-1:0] r_samples, r_awake, r_restless;
    logic [TIME_WIDTH-1:0]  f_time;
    logic [COUNT_WIDTH-1:0] t_samples, t_awake;

    always_comb begin
        q_rd_ready = !out_valid_reg || m_ready;
        pop        = q_rd_valid && q_rd_ready;

        // A gap beyond the limit closes the current run first.
        close_gap = q_rd_class.brk && in_run_reg
                    && (!best_valid_reg || (run_samples_reg > best_samples_reg));
        b_valid    = close_gap ? 1'b1             : best_valid_reg;
        b_start    = close_gap ? run_start_reg    : best_start_reg;
        b_end      = close_gap ? run_end_reg      : best_end_reg;
        b_samples  = close_gap ? run_samples_reg  : best_samples_reg;
        b_awake    = close_gap ? run_awake_reg    : best_awake_reg;
        b_restless = close_gap ? run_restless_reg : best_restless_reg;
        run_live   = in_run_reg && !q_rd_class.brk;

        r_in_run   = run_live;
        r_start    = run_start_reg;
        r_end      = run_end_reg;
        r_samples  = run_samples_reg;
        r_awake    = run_awake_reg;
        r_restless = run_restless_reg;
        if (!run_live && !q_rd_class.awake) begin
            r_in_run   = 1'b1;
            r_start    = q_rd_time;
            r_end      = q_rd_time;
            r_samples  = COUNT_WIDTH'(1);
            r_awake    = '0;
            r_restless = COUNT_WIDTH'(q_rd_class.restless);
        end else if (run_live) begin
            r_end     = q_rd_time;
            r_samples = sat_inc(run_samples_reg);
            if (q_rd_class.awake) begin
                r_awake = sat_inc(run_awake_reg);
            end
            if (q_rd_class.restless) begin
                r_restless = sat_inc(run_restless_reg);
            end
        end

        f_time    = seen_reg ? first_time_reg : q_rd_time;
        t_samples = sat_inc(total_samples_reg);
        t_awake   = q_rd_class.awake ? sat_inc(total_awake_reg) : total_awake_reg;

        close_end = r_in_run && (!b_valid || (r_samples > b_samples));

        in_run_next        = in_run_reg;
        seen_next          = seen_reg;
        run_start_next     = run_start_reg;
        run_end_next       = run_end_reg;
        run_samples_next   = run_samples_reg;
        run_awake_next     = run_awake_reg;
        run_restless_next  = run_restless_reg;
        best_valid_next    = best_valid_reg;
        best_start_next    = best_start_reg;
        best_end_next      = best_end_reg;
        best_samples_next  = best_samples_reg;
        best_awake_next    = best_awake_reg;
        best_restless_next = best_restless_reg;
        first_time_next    = first_time_reg;
        total_samples_next = total_samples_reg;
        total_awake_next   = total_awake_reg;

        out_valid_next    = out_valid_reg && !m_ready;
        out_start_next    = out_start_reg;
        out_end_next      = out_end_reg;
        out_samples_next  = out_samples_reg;
        out_awake_next    = out_awake_reg;
        out_restless_next = out_restless_reg;
        out_whole_next    = out_whole_reg;

        if (pop) begin
            if (q_rd_class.last) begin
                // The stream ends here: report and clear everything.
                in_run_next        = 1'b0;
                seen_next          = 1'b0;
                run_samples_next   = '0;
                run_awake_next     = '0;
                run_restless_next  = '0;
                best_valid_next    = 1'b0;
                best_samples_next  = '0;
                total_samples_next = '0;
                total_awake_next   = '0;

                out_valid_next = 1'b1;
                if (close_end || b_valid) begin
                    out_start_next    = close_end ? r_start    : b_start;
                    out_end_next      = close_end ? r_end      : b_end;
                    out_samples_next  = close_end ? r_samples  : b_samples;
                    out_awake_next    = close_end ? r_awake    : b_awake;
                    out_restless_next = close_end ? r_restless : b_restless;
                    out_whole_next    = 1'b0;
                end else begin
                    out_start_next    = f_time;
                    out_end_next      = q_rd_time;
                    out_samples_next  = t_samples;
                    out_awake_next    = t_awake;
                    out_restless_next = '0;
                    out_whole_next    = 1'b1;
                end
            end else begin
                in_run_next        = r_in_run;
                seen_next          = 1'b1;
                run_start_next     = r_start;
                run_end_next       = r_end;
                run_samples_next   = r_samples;
                run_awake_next     = r_awake;
                run_restless_next  = r_restless;
                best_valid_next    = b_valid;
                best_start_next    = b_start;
                best_end_next      = b_end;
                best_samples_next  = b_samples;
                best_awake_next    = b_awake;
                best_restless_next = b_restless;
                first_time_next    = f_time;
                total_samples_next = t_samples;
                total_awake_next   = t_awake;
            end
        end

        m_valid          = out_valid_reg;
        m_start_time     = out_start_reg;
        m_end_time       = out_end_reg;
        m_sample_count   = out_samples_reg;
        m_awake_count    = out_awake_reg;
        m_restless_count = out_restless_reg;
        m_whole_range    = out_whole_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg        <= 1'b0;
            seen_reg          <= 1'b0;
            run_samples_reg   <= '0;
            run_awake_reg     <= '0;
            run_restless_reg  <= '0;
            best_valid_reg    <= 1'b0;
            best_samples_reg  <= '0;
            total_samples_reg <= '0;
            total_awake_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            in_run_reg        <= in_run_next;
            seen_reg          <= seen_next;
            run_samples_reg   <= run_samples_next;
            run_awake_reg     <= run_awake_next;
            run_restless_reg  <= run_restless_next;
            best_valid_reg    <= best_valid_next;
            best_samples_reg  <= best_samples_next;
            total_samples_reg <= total_samples_next;
            total_awake_reg   <= total_awake_next;
            out_valid_reg     <= out_valid_next;
        end
        run_start_reg     <= run_start_next;
        run_end_reg       <= run_end_next;
        best_start_reg    <= best_start_next;
        best_end_reg      <= best_end_next;
        best_awake_reg    <= best_awake_next;
        best_restless_reg <= best_restless_next;
        first_time_reg    <= first_time_next;
        out_start_reg     <= out_start_next;
        out_end_reg       <= out_end_next;
        out_samples_reg   <= out_samples_next;
        out_awake_reg     <= out_awake_next;
        out_restless_reg  <= out_restless_next;
        out_whole_reg     <= out_whole_next;
    end

endmodule

// ===== design/longest_sleep_run_finder_top.sv =====
// ----------------------------------------------------------------------------
// Longest sleep run finder
// Finds the longest run of sleep samples in a time-sorted stream.
// ----------------------------------------------------------------------------
// Samples arrive as beats on the s_ channel: a timestamp, a sleep code and a
// last flag. A run starts on a sample that is not awake and breaks when two
// samples lie more than the gap limit apart. On the last beat of a stream one
// result beat leaves on the m_ channel with the longest run, or with the whole
// stream and whole_range set when no run formed; the other beats give none.
// The gap limit is to be written through cfg_wr_en and cfg_wr_data while the
// block is idle; the block does not enforce this. The block takes one sample
// beat per cycle while s_ready is high. The front end tags each sample with
// its gap break and class and writes it into a four-entry queue; the run
// tracker retires one sample per cycle and fills the result register.
// While the receiver stalls, the result holds and the tracker stops, and
// s_ready drops once the queue is full. Reset clears the queue, the run and
// stream state, and returns the gap limit to 3600 seconds.
// ----------------------------------------------------------------------------
module longest_sleep_run_finder_top #(
    parameter int COUNT_WIDTH = lsrf_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = lsrf_pkg::TIME_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [lsrf_pkg::GAP_WIDTH-1:0]       cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [TIME_WIDTH-1:0]                s_timestamp,
    input  logic [lsrf_pkg::CODE_WIDTH-1:0]      s_sleep_code,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [TIME_WIDTH-1:0]                m_start_time,
    output logic [TIME_WIDTH-1:0]                m_end_time,
    output logic [COUNT_WIDTH-1:0]               m_sample_count,
    output logic [COUNT_WIDTH-1:0]               m_awake_count,
    output logic [COUNT_WIDTH-1:0]               m_restless_count,
    output logic                                 m_whole_range
);
    import lsrf_pkg::*;

    localparam int Q_WIDTH = TIME_WIDTH + CLASS_WIDTH;

    logic                  q_wr_valid, q_wr_ready;
    logic [TIME_WIDTH-1:0] q_wr_time;
    sample_class_t         q_wr_class;
    logic                  q_rd_valid, q_rd_ready;
    logic [Q_WIDTH-1:0]    q_rd_data;
    logic [TIME_WIDTH-1:0] q_rd_time;
    sample_class_t         q_rd_class;

    assign q_rd_time  = q_rd_data[Q_WIDTH-1:CLASS_WIDTH];
    assign q_rd_class = sample_class_t'(q_rd_data[CLASS_WIDTH-1:0]);

    lsrf_front #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_timestamp  (s_timestamp),
        .s_sleep_code (s_sleep_code),
        .s_last       (s_last),
        .q_wr_valid   (q_wr_valid),
        .q_wr_ready   (q_wr_ready),
        .q_wr_time    (q_wr_time),
        .q_wr_class   (q_wr_class)
    );

    lsrf_queue #(
        .DATA_WIDTH(Q_WIDTH),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  ({q_wr_time, q_wr_class}),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    lsrf_back #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_rd_valid       (q_rd_valid),
        .q_rd_ready       (q_rd_ready),
        .q_rd_time        (q_rd_time),
        .q_rd_class       (q_rd_class),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_start_time     (m_start_time),
        .m_end_time       (m_end_time),
        .m_sample_count   (m_sample_count),
        .m_awake_count    (m_awake_count),
        .m_restless_count (m_restless_count),
        .m_whole_range    (m_whole_range)
    );

    a_whole_no_restless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_whole_range |-> m_restless_count == '0)
        else $error("Whole-range result carries restless samples.");

    a_restless_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_restless_count <= m_sample_count)
        else $error("Restless count exceeds sample count.");

    a_awake_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_awake_count <= m_sample_count && m_sample_count != '0)
        else $error("Result counts are inconsistent.");

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd_ready && !q_rd_valid && !m_ready |=> !m_valid || $past(m_valid))
        else $error("Result appeared without a queued sample.");

endmodule
